FILE: hdl/obpc_pkg.sv
// Shared types, constants and tables of the omni base pose controller.
package obpc_pkg;

  localparam int POS_BITS_DEF  = 20;
  localparam int FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SPEED_W    = 16;

  localparam int POS_FRAC      = 10;
  localparam int ROT_ITERS     = 16;
  localparam int ANG_Q16_W     = 19;
  localparam int ROT_Z_W       = ANG_Q16_W + 1;
  localparam int QUARTER_Q16   = 102944;
  localparam int QTR_MAX       = ((1 << ANG_Q16_W) - 1) / QUARTER_Q16;
  localparam int QTR_CNT_W     = $clog2(QTR_MAX + 1);
  localparam int INV_GAIN_Q16  = 39797;
  localparam int ANG_FULL_Q12  = 25736;
  localparam int ANG_HALF_Q12  = 12868;
  localparam int ANG_CLAMP_Q12 = 10718;

  localparam logic [15:0] RST_KP_LINEAR    = 16'd1638;
  localparam logic [15:0] RST_KP_ANGULAR   = 16'd4096;
  localparam logic [14:0] RST_MAX_LINEAR   = 15'd1843;
  localparam logic [14:0] RST_MAX_ANGULAR  = 15'd1843;
  localparam logic [14:0] RST_CRUISE_SPEED = 15'd1229;
  localparam logic [15:0] RST_TOL_LINEAR   = 16'd102;
  localparam logic [14:0] RST_TOL_ANGULAR  = 15'd737;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_LINEAR    = 3'd0,
    CFG_KP_ANGULAR   = 3'd1,
    CFG_MAX_LINEAR   = 3'd2,
    CFG_MAX_ANGULAR  = 3'd3,
    CFG_CRUISE_SPEED = 3'd4,
    CFG_TOL_LINEAR   = 3'd5,
    CFG_TOL_ANGULAR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    XM_ZERO   = 2'd0,
    XM_PROP   = 2'd1,
    XM_CRUISE = 2'd2
  } xmode_t;

  typedef struct packed {
    logic [15:0] kp_linear;
    logic [15:0] kp_angular;
    logic [14:0] max_linear;
    logic [14:0] max_angular;
    logic [14:0] cruise_speed;
    logic [15:0] tol_linear;
    logic [14:0] tol_angular;
  } cfg_t;

  typedef struct packed {
    xmode_t x_mode;
    logic   y_enable;
    logic   heading_enable;
  } mode_t;

  function automatic int atan_q16(input int step);
    int v;
    case (step)
      0:       v = 51472;
      1:       v = 30386;
      2:       v = 16055;
      3:       v = 8150;
      4:       v = 4091;
      5:       v = 2047;
      6:       v = 1024;
      7:       v = 512;
      8:       v = 256;
      9:       v = 128;
      10:      v = 64;
      11:      v = 32;
      12:      v = 16;
      13:      v = 8;
      14:      v = 4;
      15:      v = 2;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/obpc_in_if.sv
// Pose input channel: valid/ready with robot pose, target pose and axis modes.
interface obpc_in_if #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic signed [POS_BITS-1:0] pose_x;
  logic signed [POS_BITS-1:0] pose_y;
  logic [FRAC_BITS+2:0]   pose_heading;
  logic signed [POS_BITS-1:0] target_x;
  logic signed [POS_BITS-1:0] target_y;
  logic [FRAC_BITS+2:0]   target_heading;
  logic [1:0]             x_mode;
  logic                   y_enable;
  logic                   heading_enable;

  modport source (
    output valid, pose_x, pose_y, pose_heading, target_x, target_y, target_heading,
           x_mode, y_enable, heading_enable,
    input  ready
  );
  modport sink (
    input  valid, pose_x, pose_y, pose_heading, target_x, target_y, target_heading,
           x_mode, y_enable, heading_enable,
    output ready
  );
endinterface

FILE: hdl/obpc_out_if.sv
// Result channel: valid/ready with speed commands, robot-frame errors and flags.
interface obpc_out_if #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [obpc_pkg::SPEED_W-1:0] speed_x;
  logic signed [obpc_pkg::SPEED_W-1:0] speed_y;
  logic signed [obpc_pkg::SPEED_W-1:0] speed_turn;
  logic signed [POS_BITS:0]          err_fwd;
  logic signed [POS_BITS:0]          err_side;
  logic signed [FRAC_BITS+2:0]       err_heading;
  logic                              aligned;
  logic                              arrived;

  modport source (
    output valid, speed_x, speed_y, speed_turn, err_fwd, err_side, err_heading,
           aligned, arrived,
    input  ready
  );
  modport sink (
    input  valid, speed_x, speed_y, speed_turn, err_fwd, err_side, err_heading,
           aligned, arrived,
    output ready
  );
endinterface

FILE: hdl/obpc_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
interface obpc_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [obpc_pkg::CFG_IDX_W-1:0]  index;
  logic [obpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/omni_base_pose_p_controller.sv
// Top level of the saturated proportional pose controller for an omni base.
//
//   channel  direction  handshake     payload
//   in_ch    sink       valid/ready   robot pose, target pose, axis modes
//   out_ch   source     valid/ready   speeds, robot-frame errors, flags
//   cfg_ch   sink       valid/ready   register index, write data (always ready)
//
// One transaction per cycle while the output accepts results; the pipeline holds a front stage, 16 CORDIC
// steps and four back stages: gain multiply, saturate, speed multiply, output.
// Each stage holds its own valid bit; a stage takes new data when it is empty or
// the stage after it advances, so bubbles fill while the output waits.
// Synchronous active-low reset clears all valid bits and loads register defaults.
module omni_base_pose_p_controller #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  obpc_in_if.sink    in_ch,
  obpc_out_if.source out_ch,
  obpc_cfg_if.sink   cfg_ch
);

  localparam int W  = POS_BITS + 11;
  localparam int ZW = obpc_pkg::ROT_Z_W;
  localparam int N  = obpc_pkg::ROT_ITERS;

  obpc_pkg::cfg_t cfg;

  logic                        cv   [0:N];
  logic                        crdy [0:N];
  logic signed [W-1:0]         cx   [0:N];
  logic signed [W-1:0]         cy   [0:N];
  logic signed [ZW-1:0]        cz   [0:N];
  logic signed [FRAC_BITS+2:0] ceh  [0:N];
  obpc_pkg::mode_t             cm   [0:N];

  obpc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  obpc_prep #(
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .valid_o (cv[0]),
    .ready_i (crdy[0]),
    .x_o     (cx[0]),
    .y_o     (cy[0]),
    .z_o     (cz[0]),
    .eh_o    (ceh[0]),
    .mode_o  (cm[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_rot
    obpc_cordic_stage #(
      .POS_BITS  (POS_BITS),
      .FRAC_BITS (FRAC_BITS),
      .STEP      (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cv[i]),
      .ready_o (crdy[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .eh_i    (ceh[i]),
      .mode_i  (cm[i]),
      .valid_o (cv[i+1]),
      .ready_i (crdy[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .eh_o    (ceh[i+1]),
      .mode_o  (cm[i+1])
    );
  end

  obpc_speed #(
    .POS_BITS  (POS_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_speed (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .valid_i (cv[N]),
    .ready_o (crdy[N]),
    .x_i     (cx[N]),
    .y_i     (cy[N]),
    .eh_i    (ceh[N]),
    .mode_i  (cm[N]),
    .out_ch  (out_ch)
  );

endmodule

FILE: hdl/obpc_cfg_regs.sv
// Configuration register file for gains, limits, cruise speed and tolerances.
module obpc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  obpc_cfg_if.sink          cfg_ch,
  output obpc_pkg::cfg_t    cfg_o
);

  obpc_pkg::cfg_t cfg_r;
  obpc_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (obpc_pkg::cfg_idx_t'(cfg_ch.index))
        obpc_pkg::CFG_KP_LINEAR:    cfg_nxt.kp_linear    = cfg_ch.data;
        obpc_pkg::CFG_KP_ANGULAR:   cfg_nxt.kp_angular   = cfg_ch.data;
        obpc_pkg::CFG_MAX_LINEAR:   cfg_nxt.max_linear   = cfg_ch.data[14:0];
        obpc_pkg::CFG_MAX_ANGULAR:  cfg_nxt.max_angular  = cfg_ch.data[14:0];
        obpc_pkg::CFG_CRUISE_SPEED: cfg_nxt.cruise_speed = cfg_ch.data[14:0];
        obpc_pkg::CFG_TOL_LINEAR:   cfg_nxt.tol_linear   = cfg_ch.data;
        obpc_pkg::CFG_TOL_ANGULAR:  cfg_nxt.tol_angular  = cfg_ch.data[14:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_linear    <= obpc_pkg::RST_KP_LINEAR;
      cfg_r.kp_angular   <= obpc_pkg::RST_KP_ANGULAR;
      cfg_r.max_linear   <= obpc_pkg::RST_MAX_LINEAR;
      cfg_r.max_angular  <= obpc_pkg::RST_MAX_ANGULAR;
      cfg_r.cruise_speed <= obpc_pkg::RST_CRUISE_SPEED;
      cfg_r.tol_linear   <= obpc_pkg::RST_TOL_LINEAR;
      cfg_r.tol_angular  <= obpc_pkg::RST_TOL_ANGULAR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/obpc_prep.sv
// Front stage: world-frame error, quarter-turn reduction and heading wrap/clamp.
module obpc_prep #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  obpc_in_if.sink                             in_ch,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [POS_BITS+10:0]         x_o,
  output logic signed [POS_BITS+10:0]         y_o,
  output logic signed [obpc_pkg::ROT_Z_W-1:0] z_o,
  output logic signed [FRAC_BITS+2:0]         eh_o,
  output obpc_pkg::mode_t                     mode_o
);

  localparam int W  = POS_BITS + 11;
  localparam int AW = obpc_pkg::ANG_Q16_W;
  localparam int ZW = obpc_pkg::ROT_Z_W;
  localparam int HW = FRAC_BITS + 4;
  localparam logic signed [HW-1:0] A_FULL =
    HW'((64'(obpc_pkg::ANG_FULL_Q12) << FRAC_BITS) >> 12);
  localparam logic signed [HW-1:0] A_HALF =
    HW'((64'(obpc_pkg::ANG_HALF_Q12) << FRAC_BITS) >> 12);
  localparam logic signed [HW-1:0] A_CLAMP =
    HW'((64'(obpc_pkg::ANG_CLAMP_Q12) << FRAC_BITS) >> 12);

  logic                    valid_r;
  logic                    adv;
  logic signed [POS_BITS:0] dx, dy;
  logic signed [W-1:0]     xs, ys;
  logic [AW-1:0]           a;
  logic [AW-1:0]           rem;
  logic [obpc_pkg::QTR_CNT_W-1:0] qtr;
  logic signed [W-1:0]     x_nxt, y_nxt;
  logic signed [ZW-1:0]    z_nxt;
  logic signed [HW-1:0]    eh_raw, eh_wrap, eh_clamp;
  logic signed [W-1:0]     x_r, y_r;
  logic signed [ZW-1:0]    z_r;
  logic signed [FRAC_BITS+2:0] eh_r;
  obpc_pkg::mode_t         mode_r;
  obpc_pkg::mode_t         mode_nxt;

  assign adv         = !valid_r || ready_i;
  assign in_ch.ready = adv;

  assign dx = (POS_BITS+1)'(in_ch.target_x) - (POS_BITS+1)'(in_ch.pose_x);
  assign dy = (POS_BITS+1)'(in_ch.target_y) - (POS_BITS+1)'(in_ch.pose_y);
  assign xs = W'(dx) <<< 8;
  assign ys = W'(dy) <<< 8;
  assign a  = AW'(in_ch.pose_heading) << (16 - FRAC_BITS);

  always_comb begin
    qtr = '0;
    rem = a;
    for (int k = 1; k <= obpc_pkg::QTR_MAX; k++) begin
      if (a >= AW'(k * obpc_pkg::QUARTER_Q16)) begin
        qtr = obpc_pkg::QTR_CNT_W'(k);
        rem = a - AW'(k * obpc_pkg::QUARTER_Q16);
      end
    end
    case (qtr[1:0])
      2'd0: begin
        x_nxt = xs;
        y_nxt = ys;
      end
      2'd1: begin
        x_nxt = ys;
        y_nxt = -xs;
      end
      2'd2: begin
        x_nxt = -xs;
        y_nxt = -ys;
      end
      default: begin
        x_nxt = -ys;
        y_nxt = xs;
      end
    endcase
    z_nxt = -signed'(ZW'(rem));
  end

  always_comb begin
    eh_raw  = HW'(in_ch.target_heading) - HW'(in_ch.pose_heading);
    eh_wrap = eh_raw;
    if (eh_wrap >= A_HALF) begin
      eh_wrap = eh_wrap - A_FULL;
    end
    if (eh_wrap < -A_HALF) begin
      eh_wrap = eh_wrap + A_FULL;
    end
    if (eh_wrap > A_CLAMP) begin
      eh_clamp = A_CLAMP;
    end else if (eh_wrap < -A_CLAMP) begin
      eh_clamp = -A_CLAMP;
    end else begin
      eh_clamp = eh_wrap;
    end
    mode_nxt.x_mode         = obpc_pkg::xmode_t'(in_ch.x_mode);
    mode_nxt.y_enable       = in_ch.y_enable;
    mode_nxt.heading_enable = in_ch.heading_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      eh_r   <= eh_clamp[FRAC_BITS+2:0];
      mode_r <= mode_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign eh_o    = eh_r;
  assign mode_o  = mode_r;

endmodule

FILE: hdl/obpc_cordic_stage.sv
// One registered CORDIC rotation step with fixed shift and arctangent constant.
module obpc_cordic_stage #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [POS_BITS+10:0]         x_i,
  input  logic signed [POS_BITS+10:0]         y_i,
  input  logic signed [obpc_pkg::ROT_Z_W-1:0] z_i,
  input  logic signed [FRAC_BITS+2:0]         eh_i,
  input  obpc_pkg::mode_t                     mode_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [POS_BITS+10:0]         x_o,
  output logic signed [POS_BITS+10:0]         y_o,
  output logic signed [obpc_pkg::ROT_Z_W-1:0] z_o,
  output logic signed [FRAC_BITS+2:0]         eh_o,
  output obpc_pkg::mode_t                     mode_o
);

  localparam int W  = POS_BITS + 11;
  localparam int ZW = obpc_pkg::ROT_Z_W;
  localparam logic signed [ZW-1:0] ATAN = ZW'(obpc_pkg::atan_q16(STEP));

  logic                 valid_r;
  logic signed [W-1:0]  dx, dy;
  logic signed [W-1:0]  x_nxt, y_nxt, x_r, y_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic signed [FRAC_BITS+2:0] eh_r;
  obpc_pkg::mode_t      mode_r;

  assign ready_o = !valid_r || ready_i;
  assign dx      = y_i >>> STEP;
  assign dy      = x_i >>> STEP;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      eh_r   <= eh_i;
      mode_r <= mode_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign eh_o    = eh_r;
  assign mode_o  = mode_r;

endmodule

FILE: hdl/obpc_speed.sv
// Back stages: gain correction, saturation, proportional speeds, flags and output register.
module obpc_speed #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  obpc_pkg::cfg_t              cfg_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic signed [POS_BITS+10:0] x_i,
  input  logic signed [POS_BITS+10:0] y_i,
  input  logic signed [FRAC_BITS+2:0] eh_i,
  input  obpc_pkg::mode_t             mode_i,
  obpc_out_if.source                  out_ch
);

  localparam int W   = POS_BITS + 11;
  localparam int PW  = W + 18;
  localparam int HPW = FRAC_BITS + 21;
  localparam int LPW = POS_BITS + 19;
  localparam int CW  = (POS_BITS + 2 > 18) ? POS_BITS + 2 : 18;
  localparam int SW  = obpc_pkg::SPEED_W;
  localparam int EW  = FRAC_BITS + 3;
  localparam logic signed [PW-1:0] INV_C = PW'(obpc_pkg::INV_GAIN_Q16);
  localparam logic signed [PW-1:0] EHI   = PW'((64'sd1 <<< POS_BITS) - 64'sd1);
  localparam logic signed [PW-1:0] ELO   = -EHI - PW'(1);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: products
  logic signed [PW-1:0]  px_r, py_r;
  logic signed [HPW-1:0] ph_r;
  logic signed [EW-1:0]  eh1_r;
  obpc_pkg::mode_t       m1_r;

  // stage 2: saturated errors, turn speed, heading flag
  logic signed [PW-1:0]  rx, ry;
  logic signed [HPW-1:0] rh, hmax;
  logic signed [POS_BITS:0] efw_nxt, esd_nxt, efw_r, esd_r;
  logic signed [SW-1:0]  st_nxt, st_r;
  logic signed [CW-1:0]  tol_a;
  logic                  al_nxt, al_r;
  logic signed [EW-1:0]  eh2_r;
  obpc_pkg::mode_t       m2_r;

  // stage 3: linear products, arrival flag
  logic signed [LPW-1:0] lx_r, ly_r;
  logic signed [CW-1:0]  tol_l, efw_c, esd_c;
  logic                  ar_nxt, al3_r, ar_r;
  logic signed [POS_BITS:0] efw3_r, esd3_r;
  logic signed [SW-1:0]  st3_r;
  logic signed [EW-1:0]  eh3_r;
  obpc_pkg::mode_t       m3_r;

  // stage 4: output register
  logic signed [LPW-1:0] rlx, rly, lmax;
  logic signed [SW-1:0]  sx_nxt, sy_nxt, sxp, syp;
  logic signed [SW-1:0]  sx_r, sy_r, sturn_r;
  logic signed [POS_BITS:0] efw4_r, esd4_r;
  logic signed [EW-1:0]  eh4_r;
  logic                  al4_r, ar4_r;

  assign rdy4    = !v4_r || out_ch.ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= valid_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && valid_i) begin
      px_r  <= PW'(x_i) * INV_C;
      py_r  <= PW'(y_i) * INV_C;
      ph_r  <= HPW'(eh_i) * HPW'(signed'({1'b0, cfg_i.kp_angular}));
      eh1_r <= eh_i;
      m1_r  <= mode_i;
    end
  end

  always_comb begin
    rx = (px_r + (PW'(1) <<< 23)) >>> 24;
    ry = (py_r + (PW'(1) <<< 23)) >>> 24;
    if (rx > EHI) begin
      efw_nxt = EHI[POS_BITS:0];
    end else if (rx < ELO) begin
      efw_nxt = ELO[POS_BITS:0];
    end else begin
      efw_nxt = rx[POS_BITS:0];
    end
    if (ry > EHI) begin
      esd_nxt = EHI[POS_BITS:0];
    end else if (ry < ELO) begin
      esd_nxt = ELO[POS_BITS:0];
    end else begin
      esd_nxt = ry[POS_BITS:0];
    end
    rh   = (ph_r + (HPW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    hmax = HPW'(signed'({1'b0, cfg_i.max_angular}));
    if (rh > hmax) begin
      st_nxt = hmax[SW-1:0];
    end else if (rh < -hmax) begin
      st_nxt = -hmax[SW-1:0];
    end else begin
      st_nxt = rh[SW-1:0];
    end
    tol_a  = CW'(signed'({1'b0, cfg_i.tol_angular}));
    al_nxt = (CW'(eh1_r) <= tol_a) && (CW'(eh1_r) >= -tol_a);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      efw_r <= efw_nxt;
      esd_r <= esd_nxt;
      st_r  <= st_nxt;
      al_r  <= al_nxt;
      eh2_r <= eh1_r;
      m2_r  <= m1_r;
    end
  end

  always_comb begin
    tol_l  = CW'(signed'({1'b0, cfg_i.tol_linear}));
    efw_c  = CW'(efw_r);
    esd_c  = CW'(esd_r);
    ar_nxt = al_r && (efw_c <= tol_l) && (efw_c >= -tol_l)
                  && (esd_c <= tol_l) && (esd_c >= -tol_l);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      lx_r   <= LPW'(efw_r) * LPW'(signed'({1'b0, cfg_i.kp_linear}));
      ly_r   <= LPW'(esd_r) * LPW'(signed'({1'b0, cfg_i.kp_linear}));
      ar_r   <= ar_nxt;
      al3_r  <= al_r;
      efw3_r <= efw_r;
      esd3_r <= esd_r;
      st3_r  <= st_r;
      eh3_r  <= eh2_r;
      m3_r   <= m2_r;
    end
  end

  always_comb begin
    rlx  = (lx_r + (LPW'(1) <<< (obpc_pkg::POS_FRAC - 1))) >>> obpc_pkg::POS_FRAC;
    rly  = (ly_r + (LPW'(1) <<< (obpc_pkg::POS_FRAC - 1))) >>> obpc_pkg::POS_FRAC;
    lmax = LPW'(signed'({1'b0, cfg_i.max_linear}));
    if (rlx > lmax) begin
      sxp = lmax[SW-1:0];
    end else if (rlx < -lmax) begin
      sxp = -lmax[SW-1:0];
    end else begin
      sxp = rlx[SW-1:0];
    end
    if (rly > lmax) begin
      syp = lmax[SW-1:0];
    end else if (rly < -lmax) begin
      syp = -lmax[SW-1:0];
    end else begin
      syp = rly[SW-1:0];
    end
    case (m3_r.x_mode)
      obpc_pkg::XM_PROP:   sx_nxt = sxp;
      obpc_pkg::XM_CRUISE: sx_nxt = SW'({1'b0, cfg_i.cruise_speed});
      default:             sx_nxt = '0;
    endcase
    sy_nxt = m3_r.y_enable ? -syp : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sturn_r <= m3_r.heading_enable ? -st3_r : '0;
      efw4_r  <= efw3_r;
      esd4_r  <= esd3_r;
      eh4_r   <= eh3_r;
      al4_r   <= al3_r;
      ar4_r   <= ar_r;
    end
  end

  assign out_ch.valid       = v4_r;
  assign out_ch.speed_x     = sx_r;
  assign out_ch.speed_y     = sy_r;
  assign out_ch.speed_turn  = sturn_r;
  assign out_ch.err_fwd     = efw4_r;
  assign out_ch.err_side    = esd4_r;
  assign out_ch.err_heading = eh4_r;
  assign out_ch.aligned     = al4_r;
  assign out_ch.arrived     = ar4_r;

endmodule

FILE: hdl/obpc_checker.sv
// Port-level checks of the pose controller, bound to the top level.
module obpc_checker #(
  parameter int POS_BITS  = obpc_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = obpc_pkg::FRAC_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [obpc_pkg::SPEED_W-1:0] out_speed_x,
  input logic signed [obpc_pkg::SPEED_W-1:0] out_speed_y,
  input logic signed [obpc_pkg::SPEED_W-1:0] out_speed_turn,
  input logic signed [POS_BITS:0]            out_err_fwd,
  input logic signed [POS_BITS:0]            out_err_side,
  input logic signed [FRAC_BITS+2:0]         out_err_heading,
  input logic                                out_aligned,
  input logic                                out_arrived
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_x) && $stable(out_speed_y)
      && $stable(out_speed_turn) && $stable(out_err_fwd) && $stable(out_err_side)
      && $stable(out_err_heading) && $stable(out_aligned) && $stable(out_arrived))
    else $error("stalled result changed");

  // backpressure only from a blocked output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_arrived_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_aligned)
    else $error("arrived without aligned");

endmodule

bind omni_base_pose_p_controller obpc_checker #(
  .POS_BITS  (POS_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_obpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_speed_x     (out_ch.speed_x),
  .out_speed_y     (out_ch.speed_y),
  .out_speed_turn  (out_ch.speed_turn),
  .out_err_fwd     (out_ch.err_fwd),
  .out_err_side    (out_ch.err_side),
  .out_err_heading (out_ch.err_heading),
  .out_aligned     (out_ch.aligned),
  .out_arrived     (out_ch.arrived)
);

FILE: test/pose_cmd_checker.sv
// Watches the pose controller channels, predicts each speed command and compares it.
module pose_cmd_checker (
  input  logic clk,
  input  logic rst_n,
  obpc_in_if   in_mon,
  obpc_out_if  out_mon,
  obpc_cfg_if  cfg_mon,
  output int   mismatches,
  output int   in_flight
);

  localparam int PB = obpc_pkg::POS_BITS_DEF;
  localparam int FB = obpc_pkg::FRAC_BITS_DEF;
  localparam int SW = obpc_pkg::SPEED_W;
  localparam longint POS_HI = (longint'(1) <<< PB) - 1;
  localparam longint ATAN_Q16 [obpc_pkg::ROT_ITERS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct {
    logic signed [SW-1:0] speed_x;
    logic signed [SW-1:0] speed_y;
    logic signed [SW-1:0] speed_turn;
    logic signed [PB:0]   err_fwd;
    logic signed [PB:0]   err_side;
    logic signed [FB+2:0] err_heading;
    logic                 aligned;
    logic                 arrived;
  } speed_cmd_t;

  obpc_pkg::cfg_t regs;
  speed_cmd_t     cmd_expected[$];
  int             fails;
  int             result_no;

  assign mismatches = fails;

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic speed_cmd_t predict_cmd(
    input logic signed [PB-1:0] px,
    input logic signed [PB-1:0] py,
    input logic [FB+2:0]        ph,
    input logic signed [PB-1:0] tx,
    input logic signed [PB-1:0] ty,
    input logic [FB+2:0]        th,
    input logic [1:0]           xm,
    input logic                 ye,
    input logic                 he
  );
    speed_cmd_t r;
    longint x, y, z, a, t, dx, dy;
    longint ph_l, th_l, efw, esd, eh, sx, sy, st;
    longint kp_l, kp_a, max_l, max_a, tol_l, tol_a;
    logic al;
    int i;
    kp_l  = regs.kp_linear;
    kp_a  = regs.kp_angular;
    max_l = regs.max_linear;
    max_a = regs.max_angular;
    tol_l = regs.tol_linear;
    tol_a = regs.tol_angular;
    ph_l  = ph;
    th_l  = th;
    x = (longint'(tx) - longint'(px)) * 256;
    y = (longint'(ty) - longint'(py)) * 256;
    a = ph_l <<< (16 - FB);
    // take off whole quarter turns exactly
    while (a >= obpc_pkg::QUARTER_Q16) begin
      a -= obpc_pkg::QUARTER_Q16;
      t = x;
      x = y;
      y = -t;
    end
    z = -a;
    for (i = 0; i < obpc_pkg::ROT_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q16[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q16[i];
      end
    end
    efw = round_half_up(x * obpc_pkg::INV_GAIN_Q16, 24);
    esd = round_half_up(y * obpc_pkg::INV_GAIN_Q16, 24);
    if (efw > POS_HI) efw = POS_HI;
    else if (efw < -POS_HI - 1) efw = -POS_HI - 1;
    if (esd > POS_HI) esd = POS_HI;
    else if (esd < -POS_HI - 1) esd = -POS_HI - 1;

    eh = th_l - ph_l;
    if (eh >= obpc_pkg::ANG_HALF_Q12) eh -= obpc_pkg::ANG_FULL_Q12;
    if (eh < -obpc_pkg::ANG_HALF_Q12) eh += obpc_pkg::ANG_FULL_Q12;
    eh = clamp_sym(eh, obpc_pkg::ANG_CLAMP_Q12);

    if (xm == obpc_pkg::XM_PROP)
      sx = clamp_sym(round_half_up(efw * kp_l, obpc_pkg::POS_FRAC), max_l);
    else if (xm == obpc_pkg::XM_CRUISE) sx = regs.cruise_speed;
    else sx = 0;
    sy = ye ? clamp_sym(round_half_up(esd * kp_l, obpc_pkg::POS_FRAC), max_l) : 0;
    st = he ? clamp_sym(round_half_up(eh * kp_a, FB), max_a) : 0;

    al = (mag(eh) <= tol_a);
    r.speed_x     = SW'(sx);
    r.speed_y     = SW'(-sy);
    r.speed_turn  = SW'(-st);
    r.err_fwd     = (PB + 1)'(efw);
    r.err_side    = (PB + 1)'(esd);
    r.err_heading = (FB + 3)'(eh);
    r.aligned     = al;
    r.arrived     = al && (mag(efw) <= tol_l) && (mag(esd) <= tol_l);
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_no, msg);
    fails++;
  endtask

  initial begin
    fails     = 0;
    result_no = 0;
  end

  always @(posedge clk) begin
    speed_cmd_t want;
    if (!rst_n) begin
      regs.kp_linear    = obpc_pkg::RST_KP_LINEAR;
      regs.kp_angular   = obpc_pkg::RST_KP_ANGULAR;
      regs.max_linear   = obpc_pkg::RST_MAX_LINEAR;
      regs.max_angular  = obpc_pkg::RST_MAX_ANGULAR;
      regs.cruise_speed = obpc_pkg::RST_CRUISE_SPEED;
      regs.tol_linear   = obpc_pkg::RST_TOL_LINEAR;
      regs.tol_angular  = obpc_pkg::RST_TOL_ANGULAR;
      cmd_expected.delete();
      in_flight <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          obpc_pkg::CFG_KP_LINEAR:    regs.kp_linear    = cfg_mon.data;
          obpc_pkg::CFG_KP_ANGULAR:   regs.kp_angular   = cfg_mon.data;
          obpc_pkg::CFG_MAX_LINEAR:   regs.max_linear   = cfg_mon.data[14:0];
          obpc_pkg::CFG_MAX_ANGULAR:  regs.max_angular  = cfg_mon.data[14:0];
          obpc_pkg::CFG_CRUISE_SPEED: regs.cruise_speed = cfg_mon.data[14:0];
          obpc_pkg::CFG_TOL_LINEAR:   regs.tol_linear   = cfg_mon.data;
          obpc_pkg::CFG_TOL_ANGULAR:  regs.tol_angular  = cfg_mon.data[14:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd_expected.insert(cmd_expected.size(),
                            predict_cmd(in_mon.pose_x, in_mon.pose_y, in_mon.pose_heading,
                                        in_mon.target_x, in_mon.target_y,
                                        in_mon.target_heading, in_mon.x_mode,
                                        in_mon.y_enable, in_mon.heading_enable));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cmd_expected.size() == 0) begin
          note_mismatch("result with no transaction pending");
        end else begin
          want = cmd_expected.pop_front();
          if (out_mon.speed_x !== want.speed_x)
            note_mismatch($sformatf("speed_x got %0d expected %0d",
                                    out_mon.speed_x, want.speed_x));
          if (out_mon.speed_y !== want.speed_y)
            note_mismatch($sformatf("speed_y got %0d expected %0d",
                                    out_mon.speed_y, want.speed_y));
          if (out_mon.speed_turn !== want.speed_turn)
            note_mismatch($sformatf("speed_turn got %0d expected %0d",
                                    out_mon.speed_turn, want.speed_turn));
          if (out_mon.err_fwd !== want.err_fwd)
            note_mismatch($sformatf("err_fwd got %0d expected %0d",
                                    out_mon.err_fwd, want.err_fwd));
          if (out_mon.err_side !== want.err_side)
            note_mismatch($sformatf("err_side got %0d expected %0d",
                                    out_mon.err_side, want.err_side));
          if (out_mon.err_heading !== want.err_heading)
            note_mismatch($sformatf("err_heading got %0d expected %0d",
                                    out_mon.err_heading, want.err_heading));
          if (out_mon.aligned !== want.aligned)
            note_mismatch($sformatf("aligned got %b expected %b",
                                    out_mon.aligned, want.aligned));
          if (out_mon.arrived !== want.arrived)
            note_mismatch($sformatf("arrived got %b expected %b",
                                    out_mon.arrived, want.arrived));
        end
        result_no++;
      end
      in_flight <= cmd_expected.size();
    end
  end

endmodule

FILE: test/tb.sv
// Top of the pose controller testbench: clock, reset, stimulus, register phases and verdict.
module tb;

  localparam int PB = obpc_pkg::POS_BITS_DEF;
  localparam int FB = obpc_pkg::FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 247;
  localparam int NUM_PHASES = 7;
  localparam int CFG_SPARE = 7;
  localparam logic [1:0] XM_UNDEF = 2'd3;
  localparam int POS_MIN = -524288;
  localparam int POS_MAX = 524287;

  typedef struct {
    logic signed [PB-1:0] px;
    logic signed [PB-1:0] py;
    logic signed [PB-1:0] tx;
    logic signed [PB-1:0] ty;
    logic [FB+2:0]        ph;
    logic [FB+2:0]        th;
    logic [1:0]           xm;
    logic                 ye;
    logic                 he;
  } pose_req_t;

  logic      clk;
  logic      rst_n;
  bit        steady;
  int        mismatch_total;
  int        results_due;
  int        quiet_cycles;
  pose_req_t corners[$];

  obpc_in_if  in_if();
  obpc_out_if out_if();
  obpc_cfg_if cfg_if();

  omni_base_pose_p_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pose_cmd_checker cmd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .mismatches (mismatch_total),
    .in_flight  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic add_corner(input int px, input int py, input int tx, input int ty,
                            input int ph, input int th, input logic [1:0] xm,
                            input bit ye, input bit he);
    pose_req_t r;
    r.px = PB'(px);
    r.py = PB'(py);
    r.tx = PB'(tx);
    r.ty = PB'(ty);
    r.ph = (FB + 3)'(ph);
    r.th = (FB + 3)'(th);
    r.xm = xm;
    r.ye = ye;
    r.he = he;
    corners.insert(corners.size(), r);
  endtask

  task automatic drive_pose(input pose_req_t r);
    while (!steady && $urandom_range(99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.pose_x         <= r.px;
    in_if.pose_y         <= r.py;
    in_if.pose_heading   <= r.ph;
    in_if.target_x       <= r.tx;
    in_if.target_y       <= r.ty;
    in_if.target_heading <= r.th;
    in_if.x_mode         <= r.xm;
    in_if.y_enable       <= r.ye;
    in_if.heading_enable <= r.he;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // hold the sender until every pending transaction has produced its result
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  initial begin
    pose_req_t   req;
    logic [15:0] reg_vals [CFG_SPARE+1];
    int          kind;
    int          span;
    int          delta;

    rst_n                <= 1'b0;
    steady               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.pose_x         <= '0;
    in_if.pose_y         <= '0;
    in_if.pose_heading   <= '0;
    in_if.target_x       <= '0;
    in_if.target_y       <= '0;
    in_if.target_heading <= '0;
    in_if.x_mode         <= obpc_pkg::XM_ZERO;
    in_if.y_enable       <= 1'b0;
    in_if.heading_enable <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //         px       py       tx       ty       ph     th     xm                  ye he
    add_corner(0,       0,       0,       0,       0,     0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       0,       0,       25735, 25735, obpc_pkg::XM_ZERO,   0, 0);
    add_corner(POS_MIN, 0,       POS_MAX, 0,       0,     0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(POS_MAX, 0,       POS_MIN, 0,       0,     0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       POS_MIN, 0,       POS_MAX, 6434,  6434,  obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       POS_MAX, 0,       POS_MIN, 6433,  6433,  obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       1000,    -2000,   12868, 12868, obpc_pkg::XM_CRUISE, 1, 1);
    add_corner(500,     -700,    -300,    900,     19302, 19302, XM_UNDEF,            1, 1);
    add_corner(0,       0,       4000,    3000,    32767, 0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       0,       0,       0,     12868, obpc_pkg::XM_PROP,   0, 1);
    add_corner(0,       0,       0,       0,       0,     12867, obpc_pkg::XM_PROP,   0, 1);
    add_corner(0,       0,       0,       0,       12868, 0,     obpc_pkg::XM_ZERO,   1, 1);
    add_corner(0,       0,       0,       0,       12869, 0,     obpc_pkg::XM_ZERO,   1, 1);
    add_corner(0,       0,       102,     0,       1000,  1737,  obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       0,       102,     1000,  1738,  obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       103,     0,       0,     0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       -5,      7,       25735, 0,     obpc_pkg::XM_PROP,   1, 1);
    add_corner(0,       0,       5,       -7,      0,     25735, obpc_pkg::XM_PROP,   1, 1);
    add_corner(100,     100,     100,     100,     32767, 25735, obpc_pkg::XM_PROP,   1, 1);
    add_corner(2000,    3000,    -9000,   -8000,   4000,  200,   obpc_pkg::XM_CRUISE, 1, 1);
    add_corner(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 3217,  3217,  obpc_pkg::XM_PROP,   1, 1);
    add_corner(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 16085, 2000,  obpc_pkg::XM_PROP,   1, 0);
    foreach (corners[i]) drive_pose(corners[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: begin
            reg_vals[obpc_pkg::CFG_KP_LINEAR]    = 16'd65535;
            reg_vals[obpc_pkg::CFG_KP_ANGULAR]   = 16'd65535;
            reg_vals[obpc_pkg::CFG_MAX_LINEAR]   = 16'd32767;
            reg_vals[obpc_pkg::CFG_MAX_ANGULAR]  = 16'd32767;
            reg_vals[obpc_pkg::CFG_CRUISE_SPEED] = 16'd32767;
            reg_vals[obpc_pkg::CFG_TOL_LINEAR]   = 16'd65535;
            reg_vals[obpc_pkg::CFG_TOL_ANGULAR]  = 16'd25735;
          end
          2: begin
            foreach (reg_vals[i]) reg_vals[i] = '0;
          end
          4: begin
            reg_vals[obpc_pkg::CFG_KP_LINEAR]    = 16'($urandom_range(0, 8191));
            reg_vals[obpc_pkg::CFG_KP_ANGULAR]   = 16'($urandom_range(0, 8191));
            reg_vals[obpc_pkg::CFG_MAX_LINEAR]   = 16'($urandom_range(0, 4095));
            reg_vals[obpc_pkg::CFG_MAX_ANGULAR]  = 16'($urandom_range(0, 4095));
            reg_vals[obpc_pkg::CFG_CRUISE_SPEED] = 16'($urandom_range(0, 4095));
            reg_vals[obpc_pkg::CFG_TOL_LINEAR]   = 16'($urandom_range(0, 2047));
            reg_vals[obpc_pkg::CFG_TOL_ANGULAR]  = 16'($urandom_range(0, 2047));
          end
          default: begin
            foreach (reg_vals[i]) reg_vals[i] = 16'($urandom);
          end
        endcase
        reg_vals[CFG_SPARE] = 16'($urandom);
        cfg_if.valid <= 1'b1;
        for (int i = 0; i <= CFG_SPARE; i++) begin
          cfg_if.index <= 3'(i);
          cfg_if.data  <= reg_vals[i];
          @(posedge clk);
          while (!cfg_if.ready) @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
      end
      steady <= (phase == 3);

      repeat (PHASE_ITEMS) begin
        kind   = $urandom_range(99);
        req.px = PB'($urandom);
        req.py = PB'($urandom);
        if (kind < 45) begin
          span   = 1 << $urandom_range(2, 18);
          delta  = $urandom_range(0, 2 * span);
          req.tx = req.px + PB'(delta - span);
          delta  = $urandom_range(0, 2 * span);
          req.ty = req.py + PB'(delta - span);
        end else if (kind < 55) begin
          req.px = PB'($urandom_range(0, 1) ? POS_MIN : POS_MAX);
          req.py = PB'($urandom_range(0, 1) ? POS_MIN : POS_MAX);
          req.tx = PB'($urandom_range(0, 1) ? POS_MIN : POS_MAX);
          req.ty = PB'($urandom_range(0, 1) ? POS_MIN : POS_MAX);
        end else begin
          req.tx = PB'($urandom);
          req.ty = PB'($urandom);
        end
        req.ph = ($urandom_range(99) < 85) ? 15'($urandom_range(0, 25735))
                                          : 15'($urandom_range(25736, 32767));
        if ($urandom_range(1) == 1)
          req.th = req.ph + 15'($urandom_range(0, 1600)) - 15'd800;
        else
          req.th = ($urandom_range(99) < 85) ? 15'($urandom_range(0, 25735))
                                            : 15'($urandom_range(25736, 32767));
        req.xm = 2'($urandom);
        req.ye = 1'($urandom);
        req.he = 1'($urandom);
        drive_pose(req);
      end
    end

    drain_results();
    steady <= 1'b0;
    repeat (30) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
